FILE: hw/rtl/cfe_pkg.sv
// Shared types, codes and constants of the Cholesky factor engine.
`default_nettype none
package cfe_pkg;

  localparam int VAL_W     = 32;
  localparam int ACC_W     = 48;
  localparam int IDX_MAX_W = 8;
  localparam int SIZE_W    = 9;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_DECOMPOSE = 2'd1,
    OP_READ      = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_PD    = 2'd1;
  localparam logic [1:0] STATUS_NO_FACTOR = 2'd2;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ELEM_START,
    S_ACC_LOAD,
    S_MAC,
    S_DRAIN,
    S_PIVOT,
    S_DIVLD,
    S_ITER,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                 latch;
    logic                 cov_we;
    logic                 cov_re;
    logic                 f_re;
    logic                 f_we;
    logic                 acc_load;
    logic                 mac_issue;
    logic                 sqrt_start;
    logic                 div_start;
    logic [IDX_MAX_W-1:0] a_row;
    logic [IDX_MAX_W-1:0] a_col;
    logic [IDX_MAX_W-1:0] b_row;
    logic [IDX_MAX_W-1:0] b_col;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_pos;
    logic iter_done;
  } dp_sts_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] status;
    logic       use_rdata;
  } resp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cfe_iter.sv
// Shared iterative unit: digit-by-digit square root and restoring division.
`default_nettype none
module cfe_iter (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             sqrt_start,
  input  wire                             div_start,
  input  wire logic signed [cfe_pkg::ACC_W-1:0] acc,
  input  wire logic [31:0]                divisor,
  output logic                            done,
  output logic [31:0]                     result
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic        neg_r, neg_nxt;
  logic        ovf_r, ovf_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [63:0] src_r, src_nxt;
  logic [31:0] d_r, d_nxt;

  logic [cfe_pkg::ACC_W-1:0] acc_mag;
  logic [37:0] clampv;
  logic [33:0] shifted, trial, diff;
  logic        ge;
  logic        sat;

  always_comb begin
    acc_mag = acc[cfe_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
    clampv  = (acc_mag[cfe_pkg::ACC_W-1:38] != '0) ? '1 : acc_mag[37:0];
    shifted = sqrt_r ? {rem_r[31:0], src_r[63:62]} : {rem_r[32:0], src_r[63]};
    trial   = sqrt_r ? {root_r, 2'b01} : {2'b00, d_r};
    ge      = shifted >= trial;
    diff    = shifted - trial;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sqrt_nxt = sqrt_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    src_nxt  = src_r;
    d_nxt    = d_r;

    if (sqrt_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sqrt_nxt = 1'b1;
      neg_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
      rem_nxt  = '0;
      root_nxt = '0;
      src_nxt  = {2'b00, clampv, 24'd0};
    end else if (div_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sqrt_nxt = 1'b0;
      neg_nxt  = acc[cfe_pkg::ACC_W-1];
      // The quotient overflows 32 bits when the high part of the dividend
      // already reaches the divisor; a zero divisor lands here too.
      ovf_nxt  = (acc_mag[cfe_pkg::ACC_W-1:39] != '0) ||
                 ({1'b0, acc_mag[38:8]} >= divisor);
      rem_nxt  = {3'b000, acc_mag[38:8]};
      root_nxt = '0;
      src_nxt  = {acc_mag[7:0], 56'd0};
      d_nxt    = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff : shifted;
      root_nxt = {root_r[30:0], ge};
      src_nxt  = sqrt_r ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end

    sat = ovf_r || (neg_r ? (root_r > 32'h8000_0000) : root_r[31]);
    if (sqrt_r) begin
      result = root_r;
    end else if (sat) begin
      result = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      result = neg_r ? (~root_r + 32'd1) : root_r;
    end
    done = done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqrt_r <= sqrt_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    src_r  <= src_nxt;
    d_r    <= d_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cfe_dp.sv
// Datapath: covariance and factor memories, multiply-accumulate pipeline, root/divide unit.
`default_nettype none
module cfe_dp #(
  parameter int MAX_SIZE = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire cfe_pkg::dp_cmd_t    cmd,
  input  wire logic signed [31:0]  in_entry_value,
  output cfe_pkg::dp_sts_t         sts,
  output logic [31:0]              rdata_a
);

  localparam int IDXW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int ADDRW = $clog2(DEPTH);

  logic [31:0] cov_mem [DEPTH];
  logic [31:0] f_mem   [DEPTH];

  logic [ADDRW-1:0] a_addr, b_addr;
  logic [31:0]      val_r;
  logic [31:0]      cov_rd_r;
  logic signed [31:0] fa_r, fb_r;
  logic signed [63:0] prod_r;
  logic             v1_r, v2_r;
  logic signed [cfe_pkg::ACC_W-1:0] acc_r;
  logic [31:0]      iter_result;
  logic             iter_done;

  assign a_addr = ADDRW'(32'(cmd.a_row[IDXW-1:0]) * MAX_SIZE + 32'(cmd.a_col[IDXW-1:0]));
  assign b_addr = ADDRW'(32'(cmd.b_row[IDXW-1:0]) * MAX_SIZE + 32'(cmd.b_col[IDXW-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      val_r <= in_entry_value;
    end
    if (cmd.cov_we) begin
      cov_mem[a_addr] <= val_r;
    end
    if (cmd.cov_re) begin
      cov_rd_r <= cov_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.f_we) begin
      f_mem[a_addr] <= iter_result;
    end
    if (cmd.f_re) begin
      fa_r <= f_mem[a_addr];
      fb_r <= f_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  // The arithmetic shift of the product floors it to Q.24 before subtraction.
  always_ff @(posedge clk) begin
    prod_r <= fa_r * fb_r;
    if (cmd.acc_load) begin
      acc_r <= {{(cfe_pkg::ACC_W-32){cov_rd_r[31]}}, cov_rd_r};
    end else if (v2_r) begin
      acc_r <= acc_r - {{(cfe_pkg::ACC_W-40){prod_r[63]}}, prod_r[63:24]};
    end
  end

  cfe_iter u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .sqrt_start (cmd.sqrt_start),
    .div_start  (cmd.div_start),
    .acc        (acc_r),
    .divisor    (fa_r),
    .done       (iter_done),
    .result     (iter_result)
  );

  always_comb begin
    sts.acc_pos   = !acc_r[cfe_pkg::ACC_W-1] && (acc_r != '0);
    sts.iter_done = iter_done;
    rdata_a       = fa_r;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cfe_ctrl.sv
// Controller state machine: opcode dispatch and decomposition sequencing.
`default_nettype none
module cfe_ctrl #(
  parameter int MAX_SIZE = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [5:0]        in_row_index,
  input  wire logic [5:0]        in_col_index,
  input  wire logic [6:0]        matrix_size,
  input  wire                    cfg_clear,
  input  wire                    out_free,
  input  wire cfe_pkg::dp_sts_t  sts,
  output logic                   in_stall,
  output cfe_pkg::dp_cmd_t       cmd,
  output cfe_pkg::resp_t         resp
);

  localparam int IDXW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int IW   = cfe_pkg::IDX_MAX_W;
  localparam int SW   = cfe_pkg::SIZE_W;

  cfe_pkg::state_t state_r, state_nxt;
  cfe_pkg::op_t    op_r, op_nxt;
  logic [5:0]      row_r, row_nxt, col_r, col_nxt;
  logic [IDXW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic            drain_r, drain_nxt;
  logic            fv_r, fv_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            use_r, use_nxt;

  logic [SW-1:0]   ms9, n9, row9, col9;
  logic [IDXW-1:0] last;
  logic [5:0]      hi, lo;
  logic            in_max, in_n;

  always_comb begin
    ms9    = SW'(matrix_size);
    n9     = (ms9 == '0) ? SW'(1) : ((ms9 > SW'(MAX_SIZE)) ? SW'(MAX_SIZE) : ms9);
    last   = IDXW'(n9 - SW'(1));
    row9   = SW'(row_r);
    col9   = SW'(col_r);
    in_max = (row9 < SW'(MAX_SIZE)) && (col9 < SW'(MAX_SIZE));
    in_n   = (row9 < n9) && (col9 < n9);
    hi     = (row_r > col_r) ? row_r : col_r;
    lo     = (row_r > col_r) ? col_r : row_r;

    state_nxt  = state_r;
    op_nxt     = op_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    drain_nxt  = drain_r;
    fv_nxt     = fv_r;
    status_nxt = status_r;
    use_nxt    = use_r;
    cmd        = '0;
    resp       = '0;
    in_stall   = (state_r != cfe_pkg::S_IDLE);

    case (state_r)
      cfe_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = cfe_pkg::op_t'(in_opcode);
          row_nxt   = in_row_index;
          col_nxt   = in_col_index;
          state_nxt = cfe_pkg::S_DISPATCH;
        end
      end
      cfe_pkg::S_DISPATCH: begin
        status_nxt = cfe_pkg::STATUS_OK;
        use_nxt    = 1'b0;
        state_nxt  = cfe_pkg::S_RESP;
        case (op_r)
          cfe_pkg::OP_WRITE: begin
            if (in_max) begin
              cmd.cov_we = 1'b1;
              cmd.a_row  = IW'(hi);
              cmd.a_col  = IW'(lo);
              fv_nxt     = 1'b0;
            end
          end
          cfe_pkg::OP_READ: begin
            if (!fv_r || !in_n) begin
              status_nxt = cfe_pkg::STATUS_NO_FACTOR;
            end else if (col_r <= row_r) begin
              cmd.f_re  = 1'b1;
              cmd.a_row = IW'(row_r);
              cmd.a_col = IW'(col_r);
              use_nxt   = 1'b1;
            end
          end
          cfe_pkg::OP_DECOMPOSE: begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = cfe_pkg::S_ELEM_START;
          end
          default: begin
          end
        endcase
      end
      cfe_pkg::S_ELEM_START: begin
        cmd.cov_re = 1'b1;
        cmd.a_row  = IW'(i_r);
        cmd.a_col  = IW'(j_r);
        state_nxt  = cfe_pkg::S_ACC_LOAD;
      end
      cfe_pkg::S_ACC_LOAD: begin
        cmd.acc_load = 1'b1;
        k_nxt        = '0;
        state_nxt    = (j_r == '0) ? cfe_pkg::S_PIVOT : cfe_pkg::S_MAC;
      end
      cfe_pkg::S_MAC: begin
        cmd.f_re      = 1'b1;
        cmd.mac_issue = 1'b1;
        cmd.a_row     = IW'(i_r);
        cmd.a_col     = IW'(k_r);
        cmd.b_row     = IW'(j_r);
        cmd.b_col     = IW'(k_r);
        if (k_r == IDXW'(j_r - 1'b1)) begin
          drain_nxt = 1'b0;
          state_nxt = cfe_pkg::S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      cfe_pkg::S_DRAIN: begin
        if (drain_r) begin
          state_nxt = cfe_pkg::S_PIVOT;
        end else begin
          drain_nxt = 1'b1;
        end
      end
      cfe_pkg::S_PIVOT: begin
        if (i_r == j_r) begin
          if (!sts.acc_pos) begin
            fv_nxt     = 1'b0;
            status_nxt = cfe_pkg::STATUS_NOT_PD;
            use_nxt    = 1'b0;
            state_nxt  = cfe_pkg::S_RESP;
          end else begin
            cmd.sqrt_start = 1'b1;
            state_nxt      = cfe_pkg::S_ITER;
          end
        end else begin
          cmd.f_re  = 1'b1;
          cmd.a_row = IW'(j_r);
          cmd.a_col = IW'(j_r);
          state_nxt = cfe_pkg::S_DIVLD;
        end
      end
      cfe_pkg::S_DIVLD: begin
        cmd.div_start = 1'b1;
        state_nxt     = cfe_pkg::S_ITER;
      end
      cfe_pkg::S_ITER: begin
        if (sts.iter_done) begin
          cmd.f_we  = 1'b1;
          cmd.a_row = IW'(i_r);
          cmd.a_col = IW'(j_r);
          state_nxt = cfe_pkg::S_ELEM_START;
          if (j_r == i_r) begin
            if (i_r == last) begin
              fv_nxt     = 1'b1;
              status_nxt = cfe_pkg::STATUS_OK;
              use_nxt    = 1'b0;
              state_nxt  = cfe_pkg::S_RESP;
            end else begin
              i_nxt = i_r + 1'b1;
              j_nxt = '0;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      cfe_pkg::S_RESP: begin
        if (out_free) begin
          resp.emit = 1'b1;
          state_nxt = cfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cfe_pkg::S_IDLE;
      end
    endcase

    resp.status    = status_r;
    resp.use_rdata = use_r;

    if (cfg_clear) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cfe_pkg::S_IDLE;
      fv_r     <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      drain_r  <= 1'b0;
      status_r <= cfe_pkg::STATUS_OK;
      use_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fv_r     <= fv_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      drain_r  <= drain_nxt;
      status_r <= status_nxt;
      use_r    <= use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cholesky_factor_engine_unit.sv
// Top level of the Cholesky factor engine: configuration register, output beat register.
`default_nettype none
// A write, read or no-op beat passes the dispatch and response states; its result beat is then
// registered once the result register is free. A decompose works each lower entry (i,j) in turn:
// it loads the covariance entry, runs the one-product-per-cycle accumulate loop over k < j, then
// the one-bit-per-cycle root/divide unit (32 steps per entry).
// Throughput: one beat is worked on at a time; the next is taken once the controller is idle.
// Reset (rst_n, synchronous, active low) clears control state, sets matrix_size to 1 and marks
// the factor invalid; the memory contents are left as they are.
module cholesky_factor_engine_unit #(
  parameter int MAX_SIZE = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  // Input channel.
  input  wire                in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [5:0]    in_row_index,
  input  wire logic [5:0]    in_col_index,
  input  wire logic signed [31:0] in_entry_value,
  // Result channel.
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_factor_value,
  output logic [1:0]         out_status,
  // Configuration port.
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfe_pkg::dp_cmd_t cmd;
  cfe_pkg::dp_sts_t sts;
  cfe_pkg::resp_t   resp;
  logic [31:0]      rdata_a;

  logic [6:0]  size_r, size_nxt;
  logic        cfg_hit;
  logic        out_free;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  // The register file holds a single register; byte offset bits are ignored.
  always_comb begin
    pready   = 1'b1;
    cfg_hit  = psel && penable && pwrite && (paddr[2] == cfe_pkg::REG_MATRIX_SIZE);
    size_nxt = cfg_hit ? pwdata[6:0] : size_r;
    prdata   = (paddr[2] == cfe_pkg::REG_MATRIX_SIZE) ? {25'd0, size_r} : 32'd0;
  end

  // The result register frees up whenever the sink takes the waiting beat.
  always_comb begin
    out_free       = !out_valid_r || !out_stall;
    out_valid_nxt  = resp.emit ? 1'b1 : (out_valid_r && out_stall);
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (resp.emit) begin
      out_value_nxt  = resp.use_rdata ? rdata_a : 32'd0;
      out_status_nxt = resp.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_factor_value = out_value_r;
  assign out_status       = out_status_r;

  cfe_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .matrix_size  (size_r),
    .cfg_clear    (cfg_hit),
    .out_free     (out_free),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .resp         (resp)
  );

  cfe_dp #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_entry_value (in_entry_value),
    .sts            (sts),
    .rdata_a        (rdata_a)
  );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the Cholesky factor engine: stimulus, prediction and checking.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 64;
  // The largest decompose run here is at size six, during which no beat moves.
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    cfe_pkg::op_t op;
    logic [5:0]   row;
    logic [5:0]   col;
    logic [31:0]  value;
  } cmd_beat_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } factor_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [5:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic [31:0] in_entry_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_factor_value;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cholesky_factor_engine_unit #(.MAX_SIZE(DIM)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_factor_value(out_factor_value),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the engine: both stores, the factor flag and the size register.
  int          cov_mem [DIM*DIM];
  int          fac_mem [DIM*DIM];
  bit          fac_ok;
  logic [6:0]  size_reg;

  cmd_beat_t    pending_cmds[$];
  factor_beat_t expected_results[$];
  int           error_count = 0;
  int           quiet_cycles = 0;
  bit           calm = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Mostly short gaps, some medium, a few long; none at all during a calm stretch.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (calm) return 0;
    if (pick < 60) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 97) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int active_size();
    if (size_reg < 1) return 1;
    if (size_reg > DIM) return DIM;
    return int'(size_reg);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Row-by-row factorization; returns 0 as soon as a pivot is not positive.
  function automatic bit run_factorization(input int n);
    longint acc;
    longint prod;
    longint quot;
    longint unsigned dv;
    longint unsigned mag;
    bit neg;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= i; j++) begin
        acc = longint'(cov_mem[i*DIM+j]);
        for (int k = 0; k < j; k++) begin
          prod = longint'(fac_mem[i*DIM+k]) * longint'(fac_mem[j*DIM+k]);
          acc -= prod >>> 24;
        end
        if (i == j) begin
          if (acc <= 0) return 1'b0;
          if (acc > (longint'(1) << 38) - 1) acc = (longint'(1) << 38) - 1;
          fac_mem[i*DIM+i] = int'(int_sqrt(longint'(acc) << 24));
        end else begin
          dv = longint'(fac_mem[j*DIM+j]);
          neg = acc < 0;
          mag = neg ? -acc : acc;
          if (mag >= (64'd1 << 39) || dv == 0) quot = longint'(1) << 40;
          else quot = longint'((mag << 24) / dv);
          if (neg) quot = -quot;
          if (quot > 64'sd2147483647) quot = 64'sd2147483647;
          if (quot < -64'sd2147483648) quot = -64'sd2147483648;
          fac_mem[i*DIM+j] = int'(quot);
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic factor_beat_t predict_factor_beat(input cmd_beat_t cmd);
    factor_beat_t res;
    int n;
    int hi;
    int lo;
    res.value = '0;
    res.status = cfe_pkg::STATUS_OK;
    n = active_size();
    case (cmd.op)
      cfe_pkg::OP_WRITE: begin
        hi = (cmd.row > cmd.col) ? cmd.row : cmd.col;
        lo = (cmd.row > cmd.col) ? cmd.col : cmd.row;
        cov_mem[hi*DIM+lo] = cmd.value;
        fac_ok = 1'b0;
      end
      cfe_pkg::OP_DECOMPOSE: begin
        fac_ok = run_factorization(n);
        res.status = fac_ok ? cfe_pkg::STATUS_OK : cfe_pkg::STATUS_NOT_PD;
      end
      cfe_pkg::OP_READ: begin
        if (!fac_ok || cmd.row >= n || cmd.col >= n) res.status = cfe_pkg::STATUS_NO_FACTOR;
        else if (cmd.col <= cmd.row) res.value = fac_mem[cmd.row*DIM+cmd.col];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Input driver: a beat is held while stalled, then a random gap follows each accepted beat.
  cmd_beat_t cur_cmd;
  int        in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_factor_beat(cur_cmd));
      if (in_valid && in_stall) begin
        // Payload stays put until the engine takes it.
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_opcode <= cur_cmd.op;
        in_row_index <= cur_cmd.row;
        in_col_index <= cur_cmd.col;
        in_entry_value <= cur_cmd.value;
        in_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stalls in bursts; calm stretches switch idling off on both sides.
  int stall_left = 0;
  always @(posedge clk) begin
    if ($urandom_range(399) == 0) calm = ~calm;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(3) == 0) begin
      stall_left = gap_len();
      out_stall <= (stall_left > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: each accepted result beat is checked against the oldest prediction.
  factor_beat_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_factor_value !== want.value)
          flag_mismatch($sformatf("factor_value %h, expected %h", out_factor_value, want.value));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
  end

  // Watchdog on cycles in which no beat and no register write moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_cmd(input cfe_pkg::op_t op, input int r, input int c,
                          input logic [31:0] v);
    cmd_beat_t cmd;
    cmd.op = op;
    cmd.row = r[5:0];
    cmd.col = c[5:0];
    cmd.value = v;
    pending_cmds.push_back(cmd);
  endtask

  // Waits until every queued beat went in and every result came back.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Register write over the configuration port, only while the engine is idle.
  task automatic write_register(input int index, input logic [31:0] data);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(index * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (index == int'(cfe_pkg::REG_MATRIX_SIZE)) begin
      size_reg = data[6:0];
      fac_ok = 1'b0;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Loads the lower triangle of a size-n matrix, each entry through a random orientation.
  // Well-formed sets are diagonally dominant and hence positive definite.
  task automatic load_matrix(input int n, input bit well_formed);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j <= i; j++) begin
        if (!well_formed) v = $urandom;
        else if (i == j) v = n * 32'h0020_0000 + $urandom_range(32'h0400_0000);
        else v = 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
        if ($urandom_range(1)) push_cmd(cfe_pkg::OP_WRITE, i, j, v);
        else push_cmd(cfe_pkg::OP_WRITE, j, i, v);
      end
    end
  endtask

  task automatic read_some(input int count, input int n);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(4) == 0)
        push_cmd(cfe_pkg::OP_READ, $urandom_range(63), $urandom_range(63), $urandom);
      else
        push_cmd(cfe_pkg::OP_READ, $urandom_range(n - 1), $urandom_range(n - 1), $urandom);
    end
  endtask

  int n_pick;

  initial begin
    for (int a = 0; a < DIM*DIM; a++) begin
      cov_mem[a] = 0;
      fac_mem[a] = 0;
    end
    fac_ok = 1'b0;
    size_reg = 7'd1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset size of one: no factor yet, a no-op, zero and negative pivots,
    // then the largest pivot with reads inside and outside the matrix.
    push_cmd(cfe_pkg::OP_READ, 0, 0, '0);
    push_cmd(cfe_pkg::OP_NOP, 63, 63, 32'hFFFF_FFFF);
    push_cmd(cfe_pkg::OP_WRITE, 0, 0, 32'h0000_0000);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 0, 0, '0);
    push_cmd(cfe_pkg::OP_WRITE, 0, 0, 32'h8000_0000);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 0, 0, '0);
    push_cmd(cfe_pkg::OP_WRITE, 0, 0, 32'h7FFF_FFFF);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 63, 63, '0);
    push_cmd(cfe_pkg::OP_READ, 0, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 1, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 63, 63, '0);

    // Size two: symmetric write through the upper half, reads above the diagonal,
    // then an off-diagonal entry so large that the quotient saturates.
    write_register(0, 32'd2);
    push_cmd(cfe_pkg::OP_WRITE, 0, 0, 32'h0100_0000);
    push_cmd(cfe_pkg::OP_WRITE, 0, 1, 32'h0080_0000);
    push_cmd(cfe_pkg::OP_WRITE, 1, 1, 32'h0200_0000);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 0, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 0, 1, '0);
    push_cmd(cfe_pkg::OP_READ, 1, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 1, 1, '0);
    push_cmd(cfe_pkg::OP_WRITE, 0, 0, 32'h0000_0001);
    push_cmd(cfe_pkg::OP_WRITE, 1, 0, 32'h7FFF_FFFF);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 0, 0, '0);
    push_cmd(cfe_pkg::OP_WRITE, 1, 0, 32'h8000_0000);
    push_cmd(cfe_pkg::OP_WRITE, 1, 1, 32'h7FFF_FFFF);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 0, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 1, 1, '0);

    // A write to an unknown register index must leave the factor alone.
    write_register(1, 32'd5);
    push_cmd(cfe_pkg::OP_READ, 1, 1, '0);

    // Random rounds at small sizes: mostly well-formed sets, some noise and broken sequences.
    for (int round = 0; round < 5; round++) begin
      n_pick = $urandom_range(1, 6);
      write_register(0, (round == 3) ? 32'hFFFF_FF80 | n_pick : n_pick);
      load_matrix(n_pick, $urandom_range(4) != 0);
      if ($urandom_range(3) == 0)
        push_cmd(cfe_pkg::OP_NOP, $urandom_range(63), $urandom_range(63), $urandom);
      push_cmd(cfe_pkg::OP_DECOMPOSE, $urandom_range(63), $urandom_range(63), $urandom);
      read_some(4, n_pick);
      if ($urandom_range(3) == 0) begin
        push_cmd(cfe_pkg::OP_WRITE, $urandom_range(63), $urandom_range(63), $urandom);
        read_some(1, n_pick);
      end
    end

    // Size zero clamps to one.
    write_register(0, 32'd0);
    push_cmd(cfe_pkg::OP_DECOMPOSE, 0, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 0, 0, '0);
    push_cmd(cfe_pkg::OP_READ, 0, 1, '0);

    // Full size, then 127, which clamps to the same full size; the size write drops the factor.
    write_register(0, 32'd64);
    push_cmd(cfe_pkg::OP_READ, 63, 63, '0);
    read_some(2, DIM);
    write_register(0, 32'd127);
    push_cmd(cfe_pkg::OP_READ, 10, 5, '0);
    read_some(2, DIM);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
